// ----- hw/rtl/rts_pkg.sv -----
// ----------------------------------------------------------------------------
// rts_pkg
// Shared constants and types of the rhythm trigger sequencer.
// ----------------------------------------------------------------------------
package rts_pkg;

    localparam int TICKS_PER_BEAT    = 96;
    localparam int BEATS_PER_MEASURE = 4;
    localparam int MAX_POINTS        = 64;
    localparam int WORD_STEPS        = 16;

    localparam int AW = 6;    // table address bits
    localparam int PW = 16;   // table entry bits

    localparam logic [8:0]  WORD_SPAN   = 9'(BEATS_PER_MEASURE * TICKS_PER_BEAT);
    localparam logic [6:0]  TPB7        = 7'(TICKS_PER_BEAT);
    localparam logic [4:0]  SIXTEENTH   = 5'(TICKS_PER_BEAT / 4);
    localparam logic [20:0] ONSET_WRAP  = 21'(2048 * TICKS_PER_BEAT);

    // configuration register indexes
    localparam logic [2:0] REG_GRID_MODE       = 3'd0;
    localparam logic [2:0] REG_ONSET_COUNT     = 3'd1;
    localparam logic [2:0] REG_STEP_TICKS      = 3'd2;
    localparam logic [2:0] REG_SHIFT_TICKS     = 3'd3;
    localparam logic [2:0] REG_REPEAT_FRACTION = 3'd4;
    localparam logic [2:0] REG_RETRIGGER_EVERY = 3'd5;

    // commands
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_RESET   = 2'd1;
    localparam logic [1:0] CMD_REBUILD = 2'd2;

    typedef struct packed {
        logic          grid_mode;
        logic [3:0]    onset_count;
        logic [8:0]    step_ticks;
        logic [8:0]    shift_ticks;
        logic [8:0]    repeat_fraction;
    } build_cfg_t;

    typedef struct packed {
        logic          active;
        logic [AW-1:0] raddr;
        logic          we;
        logic [AW-1:0] waddr;
        logic [PW-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic          done;
        logic [6:0]    total;
        logic [8:0]    beats;
        logic [6:0]    limit;
        logic [AW-1:0] next_index;
    } build_stat_t;

    // pattern length in ticks
    function automatic logic [15:0] beats_to_span(input logic [8:0] beats);
        return 16'(beats) * 16'(TICKS_PER_BEAT);
    endfunction

endpackage

// ----- hw/rtl/rts_point_ram.sv -----
// ----------------------------------------------------------------------------
// rts_point_ram
// Trigger point table: one write and one registered read port. Entries never
// written since reset read as zero.
// ----------------------------------------------------------------------------
module rts_point_ram
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   we,
    input  logic [rts_pkg::AW-1:0] waddr,
    input  logic [rts_pkg::PW-1:0] wdata,
    input  logic [rts_pkg::AW-1:0] raddr,
    output logic [rts_pkg::PW-1:0] rdata
);
    import rts_pkg::*;

    logic [PW-1:0]         mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] valid_reg;
    logic [PW-1:0]         rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/rts_builder.sv -----
// ----------------------------------------------------------------------------
// rts_builder
// Rebuild sequencer: fills the point table in word or meter mode, applies the
// shift, computes the repeat limit and searches the next index.
// ----------------------------------------------------------------------------
module rts_builder
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  rts_pkg::build_cfg_t     cfg,
    input  logic [15:0]             tick_position,
    input  logic [rts_pkg::PW-1:0]  rdata,
    output rts_pkg::ram_req_t       ram,
    output rts_pkg::build_stat_t    stat
);
    import rts_pkg::*;

    localparam logic [3:0] B_IDLE   = 4'd0;
    localparam logic [3:0] B_WGEN   = 4'd1;
    localparam logic [3:0] B_WEMIT  = 4'd2;
    localparam logic [3:0] B_MDIV   = 4'd3;
    localparam logic [3:0] B_MGEN   = 4'd4;
    localparam logic [3:0] B_MSHIFT = 4'd5;
    localparam logic [3:0] B_FIN    = 4'd6;
    localparam logic [3:0] B_SRD    = 4'd7;
    localparam logic [3:0] B_SCMP   = 4'd8;
    localparam logic [3:0] B_DONE   = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [7:0]  a_reg, a_next, b_reg, b_next;
    logic [4:0]  x_reg, x_next, y_reg, y_next;
    logic [4:0]  i_reg, i_next, off_reg, off_next;
    logic [15:0] pat_reg, pat_next;
    logic [3:0]  j_reg, j_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [8:0]  sm_reg, sm_next, step_reg, step_next;
    logic [2:0]  sd_reg, sd_next;
    logic [16:0] len_reg, len_next;
    logic [6:0]  rem_reg, rem_next;
    logic [9:0]  mb_reg, mb_next;
    logic [6:0]  k_reg, k_next;
    logic [6:0]  total_reg, total_next, limit_reg, limit_next;
    logic [8:0]  beats_reg, beats_next;
    logic [AW-1:0] nidx_reg, nidx_next;

    logic [3:0]  src_j;
    logic        wbit;
    logic [9:0]  wpt;
    logic [7:0]  rsum;
    logic [16:0] spt;
    logic [15:0] span;
    logic [8:0]  frac;
    logic [16:0] lim_full;
    logic [6:0]  k_inc;

    always_comb
    begin
        state_next = state_reg;
        a_next = a_reg;  b_next = b_reg;  x_next = x_reg;  y_next = y_reg;
        i_next = i_reg;  off_next = off_reg;  pat_next = pat_reg;
        j_next = j_reg;  cnt_next = cnt_reg;
        sm_next = sm_reg;  sd_next = sd_reg;  step_next = step_reg;
        len_next = len_reg;  rem_next = rem_reg;  mb_next = mb_reg;
        k_next = k_reg;
        total_next = total_reg;  beats_next = beats_reg;
        limit_next = limit_reg;  nidx_next = nidx_reg;
        ram = '0;
        ram.active = (state_reg != B_IDLE);

        src_j    = (5'(j_reg) < off_reg) ? j_reg : 4'(5'(j_reg) - off_reg);
        wbit     = pat_reg[src_j];
        wpt      = 10'(j_reg) * 10'(SIXTEENTH) + 10'(cfg.shift_ticks);
        if (wpt >= 10'(WORD_SPAN))
        begin
            wpt = wpt - 10'(WORD_SPAN);
        end
        rsum     = {1'b0, rem_reg} + 8'(sm_reg);
        span     = beats_to_span(beats_reg);
        spt      = {1'b0, rdata} + 17'(cfg.shift_ticks);
        if (spt >= {1'b0, span})
        begin
            spt = spt - {1'b0, span};
        end
        frac     = (cfg.repeat_fraction > 9'd256) ? 9'd256 : cfg.repeat_fraction;
        lim_full = 17'(frac) * 17'(total_reg) + 17'd128;
        k_inc    = k_reg + 7'd1;

        unique case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    if (cfg.grid_mode)
                    begin
                        y_next   = (cfg.onset_count == 4'd0) ? 5'd1 : 5'(cfg.onset_count);
                        x_next   = 5'(WORD_STEPS) - y_next;
                        a_next   = 8'(y_next);
                        b_next   = 8'(x_next);
                        i_next   = 5'd1;
                        pat_next = 16'd1;
                        state_next = B_WGEN;
                    end
                    else
                    begin
                        step_next = (cfg.step_ticks == 9'd0) ? 9'd1 : cfg.step_ticks;
                        sm_next   = step_next;
                        sd_next   = 3'd0;
                        state_next = B_MDIV;
                    end
                end
            end
            B_WGEN:
            begin
                if (a_reg != b_reg && i_reg < 5'(WORD_STEPS))
                begin
                    pat_next[i_reg[3:0]] = (a_reg > b_reg);
                    if (a_reg > b_reg)
                    begin
                        b_next = b_reg + 8'(x_reg);
                    end
                    else
                    begin
                        a_next = a_reg + 8'(y_reg);
                    end
                    i_next = i_reg + 5'd1;
                end
                else
                begin
                    // a rest closes the word
                    off_next = (i_reg < 5'(WORD_STEPS)) ? i_reg + 5'd1 : i_reg;
                    j_next   = 4'd0;
                    cnt_next = 7'd0;
                    state_next = B_WEMIT;
                end
            end
            B_WEMIT:
            begin
                pat_next[j_reg] = wbit;
                if (wbit)
                begin
                    ram.we    = 1'b1;
                    ram.waddr = cnt_reg[AW-1:0];
                    ram.wdata = 16'(wpt);
                    cnt_next  = cnt_reg + 7'd1;
                end
                j_next = j_reg + 4'd1;
                if (j_reg == 4'(WORD_STEPS - 1))
                begin
                    total_next = cnt_next;
                    beats_next = 9'(BEATS_PER_MEASURE);
                    state_next = B_FIN;
                end
            end
            B_MDIV:
            begin
                if (sm_reg >= 9'(TICKS_PER_BEAT))
                begin
                    sm_next = sm_reg - 9'(TICKS_PER_BEAT);
                    sd_next = sd_reg + 3'd1;
                end
                else
                begin
                    len_next = '0;
                    rem_next = '0;
                    mb_next  = '0;
                    cnt_next = '0;
                    state_next = B_MGEN;
                end
            end
            B_MGEN:
            begin
                if (rem_reg != 7'd0 || mb_reg < 10'(BEATS_PER_MEASURE))
                begin
                    if (cnt_reg < 7'(MAX_POINTS))
                    begin
                        ram.we    = 1'b1;
                        ram.waddr = cnt_reg[AW-1:0];
                        ram.wdata = len_reg[15:0];
                        cnt_next  = cnt_reg + 7'd1;
                    end
                    len_next = len_reg + 17'(step_reg);
                    if (rsum >= 8'(TPB7))
                    begin
                        rem_next = 7'(rsum - 8'(TPB7));
                        mb_next  = mb_reg + 10'(sd_reg) + 10'd1;
                    end
                    else
                    begin
                        rem_next = rsum[6:0];
                        mb_next  = mb_reg + 10'(sd_reg);
                    end
                end
                else
                begin
                    beats_next = mb_reg[8:0];
                    total_next = cnt_reg;
                    k_next     = '0;
                    state_next = B_MSHIFT;
                end
            end
            B_MSHIFT:
            begin
                // read entry k while writing back entry k-1
                ram.raddr = k_reg[AW-1:0];
                if (k_reg != 7'd0)
                begin
                    ram.we    = 1'b1;
                    ram.waddr = 6'(k_reg - 7'd1);
                    ram.wdata = spt[15:0];
                end
                k_next = k_inc;
                if (k_reg == total_reg)
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                limit_next = (lim_full[16:8] == 9'd0) ? 7'd1 : 7'(lim_full[16:8]);
                k_next     = '0;
                state_next = B_SRD;
            end
            B_SRD:
            begin
                ram.raddr  = k_reg[AW-1:0];
                state_next = B_SCMP;
            end
            B_SCMP:
            begin
                if (rdata >= tick_position)
                begin
                    nidx_next  = k_reg[AW-1:0];
                    state_next = B_DONE;
                end
                else if (k_inc >= total_reg)
                begin
                    nidx_next  = '0;
                    state_next = B_DONE;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = B_SRD;
                end
            end
            B_DONE:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            total_reg <= 7'd1;
            beats_reg <= 9'(BEATS_PER_MEASURE);
            limit_reg <= 7'd1;
            nidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            beats_reg <= beats_next;
            limit_reg <= limit_next;
            nidx_reg  <= nidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;  b_reg <= b_next;  x_reg <= x_next;  y_reg <= y_next;
        i_reg <= i_next;  off_reg <= off_next;  pat_reg <= pat_next;
        j_reg <= j_next;  cnt_reg <= cnt_next;
        sm_reg <= sm_next;  sd_reg <= sd_next;  step_reg <= step_next;
        len_reg <= len_next;  rem_reg <= rem_next;  mb_reg <= mb_next;
        k_reg <= k_next;
    end

    assign stat.done       = (state_reg == B_DONE);
    assign stat.total      = total_reg;
    assign stat.beats      = beats_reg;
    assign stat.limit      = limit_reg;
    assign stat.next_index = nidx_reg;

endmodule

// ----- hw/rtl/rhythm_trigger_sequencer.sv -----
// ----------------------------------------------------------------------------
// rhythm_trigger_sequencer
// Tick-driven trigger sequencer over a table of trigger tick positions.
// ----------------------------------------------------------------------------
//  channel | signals                              | role
//  s       | s_tvalid s_tready s_tdata s_tuser    | commands in
//  m       | m_tvalid m_tready m_tdata            | one result per request
//  cfg     | cfg_we cfg_index cfg_data            | register writes
//
//  A tick reads the next table entry, then compares and updates in T_TICK
//  once the output is free; a position beyond a shrunk pattern is reduced in T_WRAP.
//  A reset command passes through T_REPORT. A rebuild walks the table in
//  word or meter mode and then searches it entry by entry for the next point.
//  rst_n clears the control state but not the engaged flag; the table reads as zero until written.
//  A stalled result holds in the output register; one request is in work.
// ----------------------------------------------------------------------------
module rhythm_trigger_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] engaged
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [0] fire, [18:1] onset_ticks, [33:19] position,
                                   // [40:34] point_count, [49:41] pattern_beats,
                                   // [50] locked
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    import rts_pkg::*;

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_TICK   = 3'd1;
    localparam logic [2:0] T_WRAP   = 3'd2;
    localparam logic [2:0] T_BUILD  = 3'd3;
    localparam logic [2:0] T_REPORT = 3'd4;

    build_cfg_t  bcfg_reg;
    logic [4:0]  every_reg;

    logic [2:0]  state_reg, state_next;
    logic        engaged_reg, engaged_next;
    logic [15:0] pos_reg, pos_next;
    logic [AW-1:0] nidx_reg, nidx_next;
    logic [4:0]  rcount_reg, rcount_next;
    logic [19:0] rsum_reg, rsum_next;
    logic [17:0] onset_reg, onset_next;
    logic        unlock_reg, unlock_next;
    logic        mvalid_reg, mvalid_next;
    logic [55:0] mdata_reg, mdata_next;

    ram_req_t    ram;
    build_stat_t stat;
    logic        build_start;
    logic [PW-1:0] rdata;
    logic [AW-1:0] raddr;

    logic        accept, out_free, fire;
    logic [15:0] span;
    logic [16:0] pos_inc;
    logic [6:0]  idx_inc;
    logic [4:0]  cnt_inc;
    logic [19:0] sum_inc;
    logic [20:0] onset_sum;

    function automatic logic divisible(input logic [4:0] c, input logic [4:0] d);
        logic hit;
        hit = (c == 5'd0);
        for (int k = 1; k < 32; k++)
        begin
            if (10'(k) * 10'(d) == 10'(c))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcfg_reg.grid_mode       <= 1'b1;
            bcfg_reg.onset_count     <= 4'd9;
            bcfg_reg.step_ticks      <= 9'd24;
            bcfg_reg.shift_ticks     <= 9'd0;
            bcfg_reg.repeat_fraction <= 9'd256;
            every_reg                <= 5'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_MODE:       bcfg_reg.grid_mode       <= cfg_data[0];
                REG_ONSET_COUNT:     bcfg_reg.onset_count     <= cfg_data[3:0];
                REG_STEP_TICKS:      bcfg_reg.step_ticks      <= cfg_data;
                REG_SHIFT_TICKS:     bcfg_reg.shift_ticks     <= cfg_data;
                REG_REPEAT_FRACTION: bcfg_reg.repeat_fraction <= cfg_data;
                REG_RETRIGGER_EVERY: every_reg                <= cfg_data[4:0];
                default:             every_reg                <= every_reg;
            endcase
        end
    end

    // table port: the builder owns it while it runs, else it tracks the next point
    assign raddr = ram.active ? ram.raddr : nidx_reg;

    rts_point_ram u_ram
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    rts_builder u_builder
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (build_start),
        .cfg           (bcfg_reg),
        .tick_position (pos_reg),
        .rdata         (rdata),
        .ram           (ram),
        .stat          (stat)
    );

    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign span     = beats_to_span(stat.beats);
    assign pos_inc  = {1'b0, pos_reg} + 17'd1;
    assign idx_inc  = 7'(nidx_reg) + 7'd1;
    assign cnt_inc  = rcount_reg + 5'd1;
    assign sum_inc  = rsum_reg + 20'(rdata);
    assign onset_sum = 21'(onset_reg) + 21'(sum_inc);
    assign fire     = (pos_reg == rdata) && engaged_reg && (7'(nidx_reg) < stat.limit);
    assign build_start = accept && (s_tuser == CMD_REBUILD);

    always_comb
    begin
        state_next   = state_reg;
        engaged_next = engaged_reg;
        pos_next     = pos_reg;
        nidx_next    = nidx_reg;
        rcount_next  = rcount_reg;
        rsum_next    = rsum_reg;
        onset_next   = onset_reg;
        unlock_next  = unlock_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mdata_next   = mdata_reg;

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    engaged_next = s_tdata[0];
                    priority case (s_tuser)
                        CMD_TICK:    state_next = T_TICK;
                        CMD_REBUILD: state_next = T_BUILD;
                        CMD_RESET:
                        begin
                            onset_next  = '0;
                            rcount_next = '0;
                            rsum_next   = '0;
                            pos_next    = '0;
                            nidx_next   = '0;
                            unlock_next = 1'b0;
                            state_next  = T_REPORT;
                        end
                        default:     state_next = T_REPORT;
                    endcase
                end
            end
            T_TICK:
            begin
                if (out_free)
                begin
                    unlock_next = fire;
                    if (fire && every_reg != 5'd0)
                    begin
                        if (divisible(cnt_inc, every_reg))
                        begin
                            onset_next  = (onset_sum >= ONSET_WRAP) ? 18'd0 : onset_sum[17:0];
                            rsum_next   = '0;
                            rcount_next = '0;
                        end
                        else
                        begin
                            rsum_next   = sum_inc;
                            rcount_next = cnt_inc;
                        end
                    end
                    // report the onset after this tick's advance
                    mvalid_next = 1'b1;
                    mdata_next  = {5'd0, unlock_reg, stat.beats, stat.total,
                                   pos_reg[14:0], onset_next, fire};
                    if (pos_reg == rdata)
                    begin
                        nidx_next = (idx_inc >= stat.total) ? 6'(idx_inc - stat.total)
                                                            : idx_inc[AW-1:0];
                    end
                    pos_next   = pos_inc[15:0];
                    state_next = (pos_inc >= {1'b0, span}) ? T_WRAP : T_IDLE;
                end
            end
            T_WRAP:
            begin
                // reduce the position one pattern length per cycle
                if (pos_reg >= span)
                begin
                    pos_next = pos_reg - span;
                end
                else
                begin
                    state_next = T_IDLE;
                end
            end
            T_BUILD:
            begin
                if (stat.done)
                begin
                    nidx_next  = stat.next_index;
                    state_next = T_REPORT;
                end
            end
            T_REPORT:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {5'd0, unlock_reg, stat.beats, stat.total,
                                   pos_reg[14:0], onset_reg, 1'b0};
                    state_next  = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            pos_reg     <= '0;
            nidx_reg    <= '0;
            rcount_reg  <= '0;
            rsum_reg    <= '0;
            onset_reg   <= '0;
            unlock_reg  <= 1'b0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            nidx_reg    <= nidx_next;
            rcount_reg  <= rcount_next;
            rsum_reg    <= rsum_next;
            onset_reg   <= onset_next;
            unlock_reg  <= unlock_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        engaged_reg <= engaged_next;
        mdata_reg   <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

// ----- sim/tb_rhythm_trigger_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_rhythm_trigger_sequencer
// Self-checking bench: drives commands and register settings, predicts every
// result with an independent model of the sequencer and compares field by
// field, with random gaps and stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_rhythm_trigger_sequencer;
    timeunit 1ns;
    timeprecision 1ps;
    import rts_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ONSET_LIMIT = 2048 * TICKS_PER_BEAT;

    typedef struct {
        bit          fire;
        bit [17:0]   onset_ticks;
        bit [14:0]   position;
        bit [6:0]    point_count;
        bit [8:0]    pattern_beats;
        bit          locked;
    } seq_result_t;

    class trigger_scoreboard;
        int unsigned grid_mode, onset_count, step_ticks, shift_ticks;
        int unsigned repeat_fraction, retrigger_every;
        int unsigned points[MAX_POINTS];
        int unsigned total, beats, pos, next_idx, limit;
        int unsigned rt_count, rt_sum, onset, lock_cnt;
        seq_result_t pending[$];
        int errors;

        function void clear();
            grid_mode = 1; onset_count = 9; step_ticks = 24; shift_ticks = 0;
            repeat_fraction = 256; retrigger_every = 0;
            foreach (points[i]) points[i] = 0;
            total = 1; beats = BEATS_PER_MEASURE; pos = 0; next_idx = 0; limit = 1;
            rt_count = 0; rt_sum = 0; onset = 0; lock_cnt = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, int unsigned v);
            case (idx)
                REG_GRID_MODE:       grid_mode = v & 1;
                REG_ONSET_COUNT:     onset_count = v & 'hF;
                REG_STEP_TICKS:      step_ticks = v & 'h1FF;
                REG_SHIFT_TICKS:     shift_ticks = v & 'h1FF;
                REG_REPEAT_FRACTION: repeat_fraction = v & 'h1FF;
                REG_RETRIGGER_EVERY: retrigger_every = v & 'h1F;
                default: ;
            endcase
        endfunction

        function void build_word();
            bit pat[WORD_STEPS];
            int unsigned y, x, a, b, i, off, p, span;
            y = (onset_count == 0) ? 1 : onset_count;
            x = WORD_STEPS - y;
            a = y; b = x; i = 1;
            span = BEATS_PER_MEASURE * TICKS_PER_BEAT;
            foreach (pat[k]) pat[k] = 0;
            pat[0] = 1;
            while (a != b && i < WORD_STEPS)
            begin
                if (a > b)
                begin
                    pat[i] = 1;
                    b += x;
                end
                else
                begin
                    pat[i] = 0;
                    a += y;
                end
                i++;
            end
            if (i < WORD_STEPS)
            begin
                pat[i] = 0;
                i++;
            end
            off = i;
            for (int j = 0; j + off < WORD_STEPS; j++) pat[j + off] = pat[j];
            beats = BEATS_PER_MEASURE;
            total = 0;
            for (int j = 0; j < WORD_STEPS; j++)
            begin
                if (pat[j])
                begin
                    p = j * (TICKS_PER_BEAT / 4) + shift_ticks;
                    if (p >= span) p -= span;
                    if (total < MAX_POINTS) points[total++] = p & 'hFFFF;
                end
            end
        endfunction

        function void build_meter();
            int unsigned step, len, span, p;
            step = (step_ticks == 0) ? 1 : step_ticks;
            len = 0;
            total = 0;
            while ((len % TICKS_PER_BEAT) != 0 || len < TICKS_PER_BEAT * BEATS_PER_MEASURE)
            begin
                if (total < MAX_POINTS) points[total++] = len;
                len += step;
            end
            beats = len / TICKS_PER_BEAT;
            span = beats * TICKS_PER_BEAT;
            for (int i = 0; i < total; i++)
            begin
                p = points[i] + shift_ticks;
                if (p >= span) p -= span;
                points[i] = p & 'hFFFF;
            end
        endfunction

        function void rebuild();
            int unsigned frac, lim;
            if (grid_mode) build_word();
            else build_meter();
            frac = (repeat_fraction > 256) ? 256 : repeat_fraction;
            lim = (frac * total + 128) >> 8;
            limit = (lim < 1) ? 1 : lim;
            next_idx = 0;
            for (int i = 0; i < total && i < MAX_POINTS; i++)
            begin
                if (points[i] >= pos)
                begin
                    next_idx = i;
                    break;
                end
            end
        endfunction

        // note an accepted request and queue the result it must produce
        function void note_request(logic [1:0] cmd, bit engaged);
            seq_result_t r;
            int unsigned span, idx, s;
            r.fire = 0;
            if (cmd == CMD_TICK)
            begin
                span = beats * TICKS_PER_BEAT;
                idx = (next_idx < MAX_POINTS) ? next_idx : 0;
                r.position = pos[14:0];
                r.locked = lock_cnt[0];
                if (lock_cnt > 0) lock_cnt--;
                if (pos == points[idx])
                begin
                    if (engaged && idx < limit)
                    begin
                        if (retrigger_every != 0)
                        begin
                            rt_count = (rt_count + 1) & 'h1F;
                            rt_sum = (rt_sum + points[idx]) & 'hFFFFF;
                            if (rt_count % retrigger_every == 0)
                            begin
                                s = onset + rt_sum;
                                onset = (s >= ONSET_LIMIT) ? 0 : (s & 'h3FFFF);
                                rt_sum = 0;
                                rt_count = 0;
                            end
                        end
                        r.fire = 1;
                        lock_cnt = 1;
                    end
                    next_idx = total ? (idx + 1) % total : 0;
                end
                pos = span ? (pos + 1) % span : 0;
            end
            else
            begin
                if (cmd == CMD_RESET)
                begin
                    onset = 0; rt_count = 0; rt_sum = 0;
                    pos = 0; next_idx = 0; lock_cnt = 0;
                end
                else if (cmd == CMD_REBUILD)
                    rebuild();
                r.position = pos[14:0];
                r.locked = lock_cnt[0];
            end
            r.onset_ticks = onset[17:0];
            r.point_count = total[6:0];
            r.pattern_beats = beats[8:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [55:0] d);
            seq_result_t e;
            if (pending.size() == 0)
            begin
                $error("result %h with nothing expected", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[0] !== e.fire)
            begin
                $error("fire: expected %0d, got %0d", e.fire, d[0]);
                errors++;
            end
            if (d[18:1] !== e.onset_ticks)
            begin
                $error("onset_ticks: expected %0d, got %0d", e.onset_ticks, d[18:1]);
                errors++;
            end
            if (d[33:19] !== e.position)
            begin
                $error("position: expected %0d, got %0d", e.position, d[33:19]);
                errors++;
            end
            if (d[40:34] !== e.point_count)
            begin
                $error("point_count: expected %0d, got %0d", e.point_count, d[40:34]);
                errors++;
            end
            if (d[49:41] !== e.pattern_beats)
            begin
                $error("pattern_beats: expected %0d, got %0d", e.pattern_beats, d[49:41]);
                errors++;
            end
            if (d[50] !== e.locked)
            begin
                $error("locked: expected %0d, got %0d", e.locked, d[50]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [0] engaged
    logic [1:0]  s_tuser;    // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // [0] fire, [18:1] onset, [33:19] position, [40:34] points,
                             // [49:41] beats, [50] locked
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_data;

    trigger_scoreboard sb;
    bit steady;    // no gaps or stalls in this phase

    rhythm_trigger_sequencer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: check and stall at random
    initial
    begin
        int hold;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready && rst_n) sb.check_result(m_tdata);
            hold = pick_gap();
            m_tready <= (hold == 0);
            if (hold > 1) repeat (hold - 1) @(posedge clk);
        end
    end

    task automatic send(logic [1:0] cmd, bit engaged);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'($urandom), engaged};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(cmd, engaged);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(int unsigned g, int unsigned o, int unsigned st,
                              int unsigned sh, int unsigned fr, int unsigned rt);
        int unsigned vals[6];
        logic [2:0] idx[6];
        vals = '{g, o, st, sh, fr, rt};
        idx = '{REG_GRID_MODE, REG_ONSET_COUNT, REG_STEP_TICKS, REG_SHIFT_TICKS,
                REG_REPEAT_FRACTION, REG_RETRIGGER_EVERY};
        drain();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= 9'(vals[i]);
            @(posedge clk);
            sb.set_reg(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(int n);
        int r;
        steady = ($urandom_range(0, 3) == 0);
        send(CMD_REBUILD, 1'b0);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 85) send(CMD_TICK, $urandom_range(0, 9) != 0);
            else if (r < 90) send(CMD_RESET, 1'($urandom));
            else if (r < 95) send(CMD_REBUILD, 1'($urandom));
            else send(CMD_UNUSED, 1'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        steady = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_TICK;
        cfg_we = 1'b0;
        cfg_index = REG_GRID_MODE;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any rebuild: zero table with one point at position 0
        send(CMD_TICK, 1'b1);
        send(CMD_TICK, 1'b1);
        send(CMD_UNUSED, 1'b1);
        send(CMD_RESET, 1'b0);
        send(CMD_TICK, 1'b0);
        send(CMD_RESET, 1'b1);
        send(CMD_REBUILD, 1'b1);
        repeat (10) send(CMD_TICK, 1'b1);

        // extremes: zero onsets, zero step, shift past pattern, full width values
        write_regs(0, 0, 0, 511, 0, 31);
        run_phase(50);
        write_regs(1, 15, 511, 0, 511, 1);
        run_phase(50);
        write_regs(0, 1, 6, 383, 256, 16);
        run_phase(50);
        write_regs(1, 1, 384, 383, 1, 2);
        run_phase(50);

        for (int p = 0; p < 9; p++)
        begin
            if ($urandom_range(0, 3) == 0)
                write_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                write_regs($urandom_range(0, 1), $urandom_range(1, 15),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(6, 384)
                                                       : $urandom_range(6, 48),
                           $urandom_range(0, 383), $urandom_range(0, 256),
                           $urandom_range(0, 4));
            run_phase(55);
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
